// ===== design/rhht_pkg.sv =====
package rhht_pkg;

  localparam int REQ_TYPE_W  = 2;
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 11;
  localparam int FILL_W      = 11;

  localparam logic [31:0] HASH_SEED  = 32'd5381;
  localparam int          HASH_SHIFT = 5;
  localparam logic [FILL_W-1:0] FILL_RESET = 11'd768;

  typedef enum logic [REQ_TYPE_W-1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

endpackage

// ===== design/rhht_req_if.sv =====
interface rhht_req_if;
  import rhht_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [KEY_W-1:0]      key;
  logic [VALUE_W-1:0]    value;
  modport source (output valid, req_type, key, value, input ready);
  modport sink (input valid, req_type, key, value, output ready);
endinterface

// ===== design/rhht_rsp_if.sv =====
interface rhht_rsp_if;
  import rhht_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  value_out;
  logic [COUNT_W-1:0]  item_count;
  modport source (output valid, status, value_out, item_count, input ready);
  modport sink (input valid, status, value_out, item_count, output ready);
endinterface

// ===== design/robin_hood_hash_table.sv =====
// Robin Hood hash table with linear probing and backward-shift deletion.
// Requests arrive on in_req (operation, key, value) and each produces one
// response on out_rsp (status, value found by a get, item count after it).
// The fill limit is written through cfg_we/cfg_wdata while the block is idle;
// the user must keep to this, as the block does not enforce it. All slots
// live in one synchronous memory holding tag, key and value. A request is
// taken, its key is hashed one byte at a time over KEY_BYTES bytes, the hash
// is reduced modulo CAPACITY, the search visits one slot at a time through
// the single read port, insertion or backward shift moves one slot at a
// time, and the response is loaded into the output register.
// One request is worked on at a time. A new request is taken while the
// previous response still waits in the output register; a finished
// response waits there until out_rsp.ready is high.
// After reset the memory is cleared one slot per cycle, all CAPACITY slots,
// during which in_req.ready stays low. Configuration writes are always taken.
module robin_hood_hash_table #(
  parameter int CAPACITY   = 1024,
  parameter int KEY_BYTES  = 4,
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rhht_pkg::FILL_W-1:0] cfg_wdata,
  rhht_req_if.sink                    in_req,
  rhht_rsp_if.source                  out_rsp
);
  import rhht_pkg::*;

  localparam int KW = (KEY_BYTES * 8 > 32) ? 32 : KEY_BYTES * 8;
  localparam int VW = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
  localparam int AW = $clog2(CAPACITY);
  localparam int TW = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = TW + KW + VW;
  localparam int KSTART = 2;
  localparam int BW = $clog2(KEY_BYTES + 1);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(CAPACITY));

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_MOD, S_FIND, S_PUT, S_DEL, S_DONE
  } state_t;

  state_t            state_r;
  logic [31:0]       h_r;
  logic [BW-1:0]     bi_r;
  logic [4:0]        k_r;
  logic [31:0]       q_r;
  logic [31:0]       rem_r;
  logic [AW-1:0]     home_r;
  logic [AW-1:0]     idx_r;
  logic [AW-1:0]     clr_r;
  logic [TW-1:0]     psl_r;
  logic [TW-1:0]     ctag_r;
  logic [KW-1:0]     key_r;
  logic [VW-1:0]     val_r;
  logic [KW-1:0]     ck_r;
  logic [VW-1:0]     cv_r;
  op_t               op_r;
  logic [CW-1:0]     count_r;
  logic [FILL_W-1:0] fill_r;
  status_t           res_status_r;
  logic [VW-1:0]     res_val_r;
  logic              out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_q;
  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;
  logic          re;
  logic [AW-1:0] ra;

  logic [TW-1:0] t;
  logic [KW-1:0] rkey;
  logic [VW-1:0] rval;
  logic [AW-1:0] nidx;
  logic [AW-1:0] nnidx;
  logic [7:0]    hbyte;
  logic [31:0]   h_nxt;
  logic [63:0]   prod;
  logic [31:0]   rem_nxt;
  logic          miss;
  logic          hit;
  logic          full;
  logic          last_probe;
  logic          out_free;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    if (i == AW'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = i + AW'(1);
    end
    return r;
  endfunction

  assign t    = rd_q[EW-1 -: TW];
  assign rkey = rd_q[VW +: KW];
  assign rval = rd_q[VW-1:0];
  assign nidx  = next_slot(idx_r);
  assign nnidx = next_slot(nidx);

  assign hbyte = 8'((64'(key_r)) >> (6'(8 * (KEY_BYTES - 1)) - {3'(bi_r), 3'b000}));
  assign h_nxt = ((h_r << HASH_SHIFT) + h_r) ^ 32'(hbyte);
  assign prod    = 64'(h_r) * 64'(RECIP);
  assign rem_nxt = (rem_r >= 32'(CAPACITY)) ? rem_r - 32'(CAPACITY) : rem_r;

  assign miss = (t == '0) || ((t - TW'(1)) < psl_r);
  assign hit  = !miss && (rkey == key_r);
  assign last_probe = (psl_r == TW'(CAPACITY - 1));
  assign full = (32'(count_r) >= 32'(fill_r)) || (32'(count_r) >= 32'(CAPACITY));
  assign out_free = !out_valid_r || out_rsp.ready;

  assign in_req.ready       = (state_r == S_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.value_out  = out_value_r;
  assign out_rsp.item_count = out_count_r;

  always_comb begin
    we = 1'b0;
    wa = idx_r;
    wd = '0;
    re = 1'b0;
    ra = nidx;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
      end
      S_MOD: begin
        if (k_r == '0) begin
          re = 1'b1;
          ra = rem_nxt[AW-1:0];
        end
      end
      S_FIND: begin
        if (hit) begin
          if (op_r == OP_PUT) begin
            we = 1'b1;
            wd = {t, rkey, val_r};
          end else if (op_r == OP_REMOVE) begin
            re = 1'b1;
          end
        end else if (miss || last_probe) begin
          if (op_r == OP_PUT && !full) begin
            re = 1'b1;
            ra = home_r;
          end
        end else begin
          re = 1'b1;
        end
      end
      S_PUT: begin
        if (t == '0 || ctag_r > t) begin
          we = 1'b1;
          wd = {ctag_r, ck_r, cv_r};
        end
        if (t != '0) begin
          re = 1'b1;
        end
      end
      S_DEL: begin
        we = 1'b1;
        if (!(t <= TW'(1) || last_probe)) begin
          wd = {t - TW'(1), rkey, rval};
          re = 1'b1;
          ra = nnidx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      fill_r      <= FILL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fill_r <= cfg_wdata;
      end
      if (out_rsp.valid && out_rsp.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(CAPACITY - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_req.valid) begin
            key_r     <= in_req.key[KW-1:0];
            val_r     <= in_req.value[VW-1:0];
            op_r      <= op_t'(in_req.req_type);
            h_r       <= HASH_SEED;
            bi_r      <= '0;
            res_val_r <= '0;
            if (op_t'(in_req.req_type) == OP_NONE) begin
              res_status_r <= ST_NOT_FOUND;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          h_r  <= h_nxt;
          bi_r <= bi_r + BW'(1);
          if (bi_r == BW'(KEY_BYTES - 1)) begin
            k_r     <= 5'(KSTART);
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          k_r <= k_r - 5'd1;
          if (k_r == 5'd2) begin
            q_r <= prod[63:32];
          end else if (k_r == 5'd1) begin
            rem_r <= h_r - 32'(64'(q_r) * 64'(CAPACITY));
          end
          if (k_r == '0) begin
            home_r  <= rem_nxt[AW-1:0];
            idx_r   <= rem_nxt[AW-1:0];
            psl_r   <= '0;
            state_r <= S_FIND;
          end
        end
        S_FIND: begin
          if (hit) begin
            case (op_r)
              OP_PUT: begin
                res_status_r <= ST_UPDATED;
                state_r      <= S_DONE;
              end
              OP_GET: begin
                res_status_r <= ST_FOUND;
                res_val_r    <= rval;
                state_r      <= S_DONE;
              end
              default: begin
                psl_r   <= '0;
                state_r <= S_DEL;
              end
            endcase
          end else if (miss || last_probe) begin
            if (op_r == OP_PUT && full) begin
              res_status_r <= ST_FULL;
              state_r      <= S_DONE;
            end else if (op_r == OP_PUT) begin
              idx_r   <= home_r;
              ctag_r  <= TW'(1);
              ck_r    <= key_r;
              cv_r    <= val_r;
              state_r <= S_PUT;
            end else begin
              res_status_r <= ST_NOT_FOUND;
              state_r      <= S_DONE;
            end
          end else begin
            idx_r <= nidx;
            psl_r <= psl_r + TW'(1);
          end
        end
        S_PUT: begin
          if (t == '0) begin
            count_r      <= count_r + CW'(1);
            res_status_r <= ST_INSERTED;
            state_r      <= S_DONE;
          end else begin
            if (ctag_r > t) begin
              ctag_r <= t + TW'(1);
              ck_r   <= rkey;
              cv_r   <= rval;
            end else begin
              ctag_r <= ctag_r + TW'(1);
            end
            idx_r <= nidx;
          end
        end
        S_DEL: begin
          if (t <= TW'(1) || last_probe) begin
            if (count_r != '0) begin
              count_r <= count_r - CW'(1);
            end
            res_status_r <= ST_REMOVED;
            state_r      <= S_DONE;
          end else begin
            idx_r <= nidx;
            psl_r <= psl_r + TW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_value_r  <= 32'(res_val_r);
            out_count_r  <= 11'(count_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(CAPACITY))
    else $error("item count above capacity");

  a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready && in_req.req_type != OP_NONE |=> state_r == S_HASH)
    else $error("accepted request did not start hashing");

  a_find_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIND && we |-> op_r == OP_PUT && hit)
    else $error("unexpected write during search");

  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("response not presented");

endmodule
